// File: sv/tgi_pkg.sv
// ----------------------------------------------------------------------------
// tgi_pkg: shared definitions of the trilinear grid interpolator
// Grid geometry, datapath widths, register indexes and the structs that
// pass between the register bank, the axis mappers and the top level.
// ----------------------------------------------------------------------------
package tgi_pkg;

   // grid geometry
   localparam int ALPHA_POINTS = 16;
   localparam int THETA_POINTS = 16;
   localparam int Q_POINTS     = 16;

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   localparam int MAXP_AT = (ALPHA_POINTS > THETA_POINTS) ? ALPHA_POINTS : THETA_POINTS;
   localparam int MAXP    = (MAXP_AT > Q_POINTS) ? MAXP_AT : Q_POINTS;
   // an axis index never exceeds points-1
   localparam int IDX_W   = $clog2(MAXP);
   localparam int FLAT_W  = (3 * IDX_W > ADDR_W) ? 3 * IDX_W : ADDR_W;

   // datapath widths
   localparam int COORD_W = 32;
   localparam int SCALE_W = 24;
   localparam int HALF_W  = 31;
   localparam int FRAC_W  = 16;
   localparam int WGT_W   = FRAC_W + 1;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int P_W     = DIFF_W + SCALE_W + 1;
   localparam int IP_W    = P_W - 2 * FRAC_W;
   localparam int PROD_W  = COORD_W + WGT_W + 1;
   localparam int TERM_W  = PROD_W - FRAC_W;
   localparam int SUM_W   = TERM_W + 3;

   localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_W;

   // transaction opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register indexes
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA_ORIGIN        = 3'd0,
      CSR_THETA_ORIGIN        = 3'd1,
      CSR_Q_ORIGIN            = 3'd2,
      CSR_ALPHA_SCALE         = 3'd3,
      CSR_THETA_SCALE         = 3'd4,
      CSR_Q_SCALE             = 3'd5,
      CSR_TARGET_ALPHA_HALF   = 3'd6,
      CSR_TARGET_THETA_Q_HALF = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] alpha_origin;
      logic signed [COORD_W-1:0] theta_origin;
      logic signed [COORD_W-1:0] q_origin;
      logic [SCALE_W-1:0]        alpha_scale;
      logic [SCALE_W-1:0]        theta_scale;
      logic [SCALE_W-1:0]        q_scale;
      logic [HALF_W-1:0]         target_alpha_half;
      logic [HALF_W-1:0]         target_theta_q_half;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [FRAC_W-1:0] frac;
      logic              clamp;
   } axis_type;

endpackage

// File: sv/tgi_table.sv
// ----------------------------------------------------------------------------
// tgi_table: value table
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module tgi_table (
   input  logic                       clock,
   input  logic                       en,
   input  logic                       we,
   input  logic [tgi_pkg::ADDR_W-1:0] addr,
   input  logic [tgi_pkg::COORD_W-1:0] wdata,
   output logic [tgi_pkg::COORD_W-1:0] rdata
);

   logic [tgi_pkg::COORD_W-1:0] mem [tgi_pkg::TABLE_DEPTH];
   logic [tgi_pkg::COORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/tgi_csr.sv
// ----------------------------------------------------------------------------
// tgi_csr: configuration register bank
// Eight registers written by index; all fields come out as one struct.
// ----------------------------------------------------------------------------
module tgi_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [tgi_pkg::CSR_IDX_W-1:0] wr_index,
   input  logic [tgi_pkg::COORD_W-1:0]   wr_data,
   output tgi_pkg::cfg_type              cfg
);

   localparam int SCALE_W = tgi_pkg::SCALE_W;
   localparam int HALF_W  = tgi_pkg::HALF_W;

   tgi_pkg::cfg_type cfg_ff;
   tgi_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (tgi_pkg::csr_index_type'(wr_index))
            tgi_pkg::CSR_ALPHA_ORIGIN:        cfg_in.alpha_origin = wr_data;
            tgi_pkg::CSR_THETA_ORIGIN:        cfg_in.theta_origin = wr_data;
            tgi_pkg::CSR_Q_ORIGIN:            cfg_in.q_origin     = wr_data;
            tgi_pkg::CSR_ALPHA_SCALE:         cfg_in.alpha_scale  = wr_data[SCALE_W-1:0];
            tgi_pkg::CSR_THETA_SCALE:         cfg_in.theta_scale  = wr_data[SCALE_W-1:0];
            tgi_pkg::CSR_Q_SCALE:             cfg_in.q_scale      = wr_data[SCALE_W-1:0];
            tgi_pkg::CSR_TARGET_ALPHA_HALF:   cfg_in.target_alpha_half = wr_data[HALF_W-1:0];
            tgi_pkg::CSR_TARGET_THETA_Q_HALF: cfg_in.target_theta_q_half = wr_data[HALF_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_origin        <= '0;
         cfg_ff.theta_origin        <= '0;
         cfg_ff.q_origin            <= '0;
         cfg_ff.alpha_scale         <= SCALE_W'(65536);
         cfg_ff.theta_scale         <= SCALE_W'(65536);
         cfg_ff.q_scale             <= SCALE_W'(65536);
         cfg_ff.target_alpha_half   <= HALF_W'(3277);   // 0.05 in Q16.16
         cfg_ff.target_theta_q_half <= HALF_W'(6554);   // 0.1 in Q16.16
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/tgi_axis_map.sv
// ----------------------------------------------------------------------------
// tgi_axis_map: coordinate to grid cell mapping for one axis
// Registers (coord - origin) * scale, then clamps the integer part to the
// grid and saturates the fraction.
// ----------------------------------------------------------------------------
module tgi_axis_map (
   input  logic                               clock,
   input  logic                               load,
   input  logic signed [tgi_pkg::COORD_W-1:0] coord,
   input  logic signed [tgi_pkg::COORD_W-1:0] origin,
   input  logic [tgi_pkg::SCALE_W-1:0]        scale,
   input  logic [tgi_pkg::IDX_W-1:0]          top_idx,
   output tgi_pkg::axis_type                  res
);

   localparam int P_W    = tgi_pkg::P_W;
   localparam int IP_W   = tgi_pkg::IP_W;
   localparam int IDX_W  = tgi_pkg::IDX_W;
   localparam int FRAC_W = tgi_pkg::FRAC_W;

   logic signed [tgi_pkg::DIFF_W-1:0] diff;
   logic signed [P_W-1:0]             p_full;
   logic signed [P_W-1:0]             p_ff;
   logic [IP_W-1:0]                   ip;
   logic                              below;
   logic                              above;

   assign diff   = {coord[tgi_pkg::COORD_W-1], coord} - {origin[tgi_pkg::COORD_W-1], origin};
   assign p_full = diff * $signed({1'b0, scale});

   always_ff @(posedge clock) begin
      if (load) begin
         p_ff <= p_full;
      end
   end

   // integer part is floor(p / 2^32)
   assign ip    = p_ff[P_W-1:2*FRAC_W];
   assign below = ip[IP_W-1];
   assign above = !below && ((|ip[IP_W-2:IDX_W]) || (ip[IDX_W-1:0] > top_idx));

   always_comb begin
      res.clamp = below | above;
      if (below) begin
         res.idx  = '0;
         res.frac = '0;
      end else if (above) begin
         res.idx  = top_idx;
         res.frac = '1;
      end else begin
         res.idx  = ip[IDX_W-1:0];
         res.frac = p_ff[2*FRAC_W-1:FRAC_W];
      end
   end

endmodule

// File: sv/trilinear_grid_interpolator.sv
// ----------------------------------------------------------------------------
// trilinear_grid_interpolator: 3-D table lookup with trilinear blending
// Write transactions fill the value table; query transactions return the
// blend of the eight grid corners around a point, or zero in the target box.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  opcode, coords, entry index/value
//   rsp      out        rsp_valid / rsp_ready  result_value, in_target, out_of_range
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// A write completes in idle. A query inside the target box goes straight
// to the result register; any other query takes one mapping state, eight
// reads of the single table port and a three-stage weight/multiply/accumulate
// pipe that drains before the result is registered. After reset all 4096
// entries are cleared, one a cycle, with req_ready low; csr writes are taken.
// A pending rsp transaction does not block the next request; only the final
// result load waits for the output register to empty.
// ----------------------------------------------------------------------------
module trilinear_grid_interpolator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_opcode,
   input  logic signed [tgi_pkg::COORD_W-1:0]    req_alpha_coord,
   input  logic signed [tgi_pkg::COORD_W-1:0]    req_theta_coord,
   input  logic signed [tgi_pkg::COORD_W-1:0]    req_q_coord,
   input  logic [tgi_pkg::ADDR_W-1:0]            req_entry_index,
   input  logic signed [tgi_pkg::COORD_W-1:0]    req_entry_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tgi_pkg::COORD_W-1:0]    rsp_result_value,
   output logic                                  rsp_in_target,
   output logic                                  rsp_out_of_range,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tgi_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tgi_pkg::COORD_W-1:0]           csr_wdata
);

   localparam int ADDR_W  = tgi_pkg::ADDR_W;
   localparam int IDX_W   = tgi_pkg::IDX_W;
   localparam int FLAT_W  = tgi_pkg::FLAT_W;
   localparam int COORD_W = tgi_pkg::COORD_W;
   localparam int FRAC_W  = tgi_pkg::FRAC_W;
   localparam int WGT_W   = tgi_pkg::WGT_W;
   localparam int PROD_W  = tgi_pkg::PROD_W;
   localparam int TERM_W  = tgi_pkg::TERM_W;
   localparam int SUM_W   = tgi_pkg::SUM_W;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_MAP    = 6'b000100,
      ST_CORNER = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   function automatic logic in_box(input logic signed [COORD_W-1:0] c,
                                   input logic [tgi_pkg::HALF_W-1:0] half);
      logic signed [COORD_W:0] cx;
      logic signed [COORD_W:0] hx;
      cx = {c[COORD_W-1], c};
      hx = $signed({2'b00, half});
      return (cx <= hx) && (cx >= -hx);
   endfunction

   // ---------------------------------------------------------------- config
   tgi_pkg::cfg_type cfg;

   assign csr_ready = 1'b1;

   tgi_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // ---------------------------------------------------------------- control
   state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]         clr_ff, clr_in;
   logic [2:0]                cnt_ff, cnt_in;
   logic                      in_target_ff, in_target_in;
   logic                      oor_ff, oor_in;
   logic                      req_fire;
   logic                      query_fire;
   logic                      box_hit;
   logic                      corner_issue;
   logic                      map_capture;
   logic                      rsp_load;
   logic [2:0]                pipe_vld_ff;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic                      mem_en, mem_we;
   logic [ADDR_W-1:0]         mem_addr;
   logic [COORD_W-1:0]        mem_wdata, mem_rdata;

   tgi_pkg::axis_type         ax_a, ax_t, ax_q;
   logic [IDX_W-1:0]          ia_ff, it_ff, iq_ff;
   logic [FRAC_W-1:0]         fa_ff, ft_ff, fq_ff;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid & req_ready;
   assign query_fire = req_fire & (req_opcode == tgi_pkg::OP_QUERY);
   assign box_hit    = in_box(req_alpha_coord, cfg.target_alpha_half) &&
                       in_box(req_theta_coord, cfg.target_theta_q_half) &&
                       in_box(req_q_coord, cfg.target_theta_q_half);

   tgi_axis_map u_map_alpha (
      .clock   (clock),
      .load    (query_fire),
      .coord   (req_alpha_coord),
      .origin  (cfg.alpha_origin),
      .scale   (cfg.alpha_scale),
      .top_idx (IDX_W'(tgi_pkg::ALPHA_POINTS - 2)),
      .res     (ax_a)
   );

   tgi_axis_map u_map_theta (
      .clock   (clock),
      .load    (query_fire),
      .coord   (req_theta_coord),
      .origin  (cfg.theta_origin),
      .scale   (cfg.theta_scale),
      .top_idx (IDX_W'(tgi_pkg::THETA_POINTS - 2)),
      .res     (ax_t)
   );

   tgi_axis_map u_map_q (
      .clock   (clock),
      .load    (query_fire),
      .coord   (req_q_coord),
      .origin  (cfg.q_origin),
      .scale   (cfg.q_scale),
      .top_idx (IDX_W'(tgi_pkg::Q_POINTS - 2)),
      .res     (ax_q)
   );

   // corner address, alpha-major, wraps to the table depth
   logic [IDX_W-1:0]  ia_c, it_c, iq_c;
   logic [FLAT_W-1:0] flat;

   assign ia_c = ia_ff + IDX_W'(cnt_ff[2]);
   assign it_c = it_ff + IDX_W'(cnt_ff[1]);
   assign iq_c = iq_ff + IDX_W'(cnt_ff[0]);
   assign flat = (FLAT_W'(ia_c) * FLAT_W'(tgi_pkg::THETA_POINTS) + FLAT_W'(it_c)) *
                 FLAT_W'(tgi_pkg::Q_POINTS) + FLAT_W'(iq_c);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      in_target_in = in_target_ff;
      oor_in       = oor_ff;
      corner_issue = 1'b0;
      map_capture  = 1'b0;
      rsp_load     = 1'b0;
      mem_en       = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = flat[ADDR_W-1:0];
      mem_wdata    = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + ADDR_W'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_opcode == tgi_pkg::OP_WRITE) begin
                  mem_en    = 1'b1;
                  mem_we    = 1'b1;
                  mem_addr  = req_entry_index;
                  mem_wdata = req_entry_value;
               end else if (box_hit) begin
                  in_target_in = 1'b1;
                  oor_in       = 1'b0;
                  state_in     = ST_FINISH;
               end else begin
                  in_target_in = 1'b0;
                  state_in     = ST_MAP;
               end
            end
         end
         ST_MAP: begin
            map_capture = 1'b1;
            oor_in      = ax_a.clamp | ax_t.clamp | ax_q.clamp;
            cnt_in      = '0;
            state_in    = ST_CORNER;
         end
         ST_CORNER: begin
            mem_en       = 1'b1;
            corner_issue = 1'b1;
            cnt_in       = cnt_ff + 3'd1;
            if (&cnt_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_vld_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   tgi_table u_table (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_target_ff <= in_target_in;
      oor_ff       <= oor_in;
      if (map_capture) begin
         ia_ff <= ax_a.idx;
         it_ff <= ax_t.idx;
         iq_ff <= ax_q.idx;
         fa_ff <= ax_a.frac;
         ft_ff <= ax_t.frac;
         fq_ff <= ax_q.frac;
      end
   end

   // ---------------------------------------------------------------- blend pipe
   // s1: alpha*theta weight, table data; s2: full weight; s3: corner product.
   // Table writes happen only while clearing or idle, so reads never meet a pending write.
   logic [WGT_W-1:0]          wa_sel, wt_sel, wq_sel;
   logic [2*WGT_W-1:0]        wat_prod, w_prod;
   logic [WGT_W-1:0]          wat_ff, w_ff;
   logic                      dq_s1_ff;
   logic [COORD_W-1:0]        val_ff;
   logic signed [PROD_W-1:0]  prod;
   logic [TERM_W-1:0]         term_ff;
   logic [SUM_W-1:0]          sum_ff;

   assign wa_sel   = cnt_ff[2] ? {1'b0, fa_ff} : tgi_pkg::WGT_ONE - {1'b0, fa_ff};
   assign wt_sel   = cnt_ff[1] ? {1'b0, ft_ff} : tgi_pkg::WGT_ONE - {1'b0, ft_ff};
   assign wq_sel   = dq_s1_ff  ? {1'b0, fq_ff} : tgi_pkg::WGT_ONE - {1'b0, fq_ff};
   assign wat_prod = wa_sel * wt_sel;
   assign w_prod   = wat_ff * wq_sel;
   assign prod     = $signed(val_ff) * $signed({1'b0, w_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_vld_ff <= '0;
      end else begin
         pipe_vld_ff <= {pipe_vld_ff[1:0], corner_issue};
      end
   end

   always_ff @(posedge clock) begin
      wat_ff   <= wat_prod[FRAC_W+WGT_W-1:FRAC_W];
      dq_s1_ff <= cnt_ff[0];
      w_ff     <= w_prod[FRAC_W+WGT_W-1:FRAC_W];
      val_ff   <= mem_rdata;
      term_ff  <= prod[PROD_W-1:FRAC_W];   // floor shift
      if (map_capture) begin
         sum_ff <= '0;
      end else if (pipe_vld_ff[2]) begin
         sum_ff <= sum_ff + {{(SUM_W-TERM_W){term_ff[TERM_W-1]}}, term_ff};
      end
   end

   // ---------------------------------------------------------------- result
   logic                      sat_hi, sat_lo;
   logic [COORD_W-1:0]        blend;
   logic [COORD_W-1:0]        rsp_value_ff;
   logic                      rsp_in_target_ff, rsp_oor_ff;

   assign sat_hi = !sum_ff[SUM_W-1] && (|sum_ff[SUM_W-2:COORD_W-1]);
   assign sat_lo = sum_ff[SUM_W-1] && !(&sum_ff[SUM_W-2:COORD_W-1]);

   always_comb begin
      if (in_target_ff) begin
         blend = '0;
      end else if (sat_hi) begin
         blend = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (sat_lo) begin
         blend = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         blend = sum_ff[COORD_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff     <= blend;
         rsp_in_target_ff <= in_target_ff;
         rsp_oor_ff       <= oor_ff & !in_target_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_in_target    = rsp_in_target_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // ---------------------------------------------------------------- checks
   a_target_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_target |-> (rsp_result_value == '0) && !rsp_out_of_range)
      else $error("in-target response with non-zero value or range flag");

   a_pipe_source: assert property (@(posedge clock) disable iff (reset)
      pipe_vld_ff[0] |-> $past(state_ff == ST_CORNER))
      else $error("blend pipe entered outside the corner sweep");

   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (pipe_vld_ff == '0))
      else $error("result loaded with corners still in flight");

   a_write_window: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR) || (state_ff == ST_IDLE))
      else $error("table write outside clear or idle");

endmodule
